// ===== hw/rtl/dtsi_pkg.sv =====
// Shared types and constants for the decimal text to scaled integer core.
// Holds the request queue entry layout, state enums and character codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtsi_pkg;

    localparam int VALUE_W     = 64;
    localparam int PLACES_W    = 5;
    localparam int CFG_DATA_W  = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic CFG_FRACTION_PLACES = 1'b0;
    localparam logic CFG_NARROW_RESULT   = 1'b1;

    localparam logic [PLACES_W-1:0] PLACES_RESET = 5'd3;

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [1:0] {
        PS_OK      = 2'd0,
        PS_INVALID = 2'd1,
        PS_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_WS      = 2'd0,
        ST_SIGN    = 2'd1,
        ST_DIGITS  = 2'd2,
        ST_STOPPED = 2'd3
    } stage_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_PAD,
        BK_DONE
    } bk_state_t;

    // One unit of work for the arithmetic side
    typedef struct packed {
        logic                has_digit;
        logic [3:0]          digit;
        logic                finish;
        logic                discard;
        logic [PLACES_W-1:0] pad;
        logic                invalid;
        logic                neg;
    } qent_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtsi_front.sv =====
// Front end: accepts characters, tracks the parse phase and emits digit
// and finish requests into the queue. Depends on dtsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtsi_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    text_char,
    input  wire logic                          last_char,
    input  wire logic                          empty_text,
    input  wire logic [dtsi_pkg::PLACES_W-1:0] fraction_places,
    output logic                               q_push,
    output dtsi_pkg::qent_t                    q_entry,
    input  wire logic                          q_full
);
    import dtsi_pkg::*;

    stage_t              stage_reg, stage_next, stage_step;
    logic                frac_reg, frac_next, frac_step;
    logic [PLACES_W-1:0] fcount_reg, fcount_next, fcount_step;
    logic                neg_reg, neg_next, neg_step;
    logic                inv_reg, inv_next, inv_step;

    logic                accept;
    logic                is_digit, is_dot, is_space, is_sign, skip;
    logic [PLACES_W-1:0] pad_calc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
        is_dot   = (text_char == CHAR_DOT);
        is_space = (text_char == CHAR_SPACE)
                   || ((text_char >= CHAR_TAB) && (text_char <= CHAR_CR));
        is_sign  = (text_char == CHAR_PLUS) || (text_char == CHAR_MINUS);
        skip     = (stage_reg == ST_STOPPED) || (frac_reg && (fcount_reg >= fraction_places));
    end

    // Next parse state
    always_comb
    begin
        stage_step  = stage_reg;
        frac_step   = frac_reg;
        fcount_step = fcount_reg;
        neg_step    = neg_reg;
        inv_step    = inv_reg;
        if (!skip)
        begin
            priority if (is_digit)
            begin
                stage_step = ST_DIGITS;
                if (frac_reg)
                    fcount_step = fcount_reg + 1'b1;
            end
            else if (is_dot && !frac_reg)
                frac_step = 1'b1;
            else if ((stage_reg == ST_WS) && is_space)
            begin
                if (frac_reg)
                    fcount_step = fcount_reg + 1'b1;
            end
            else if ((stage_reg == ST_WS) && is_sign)
            begin
                neg_step   = (text_char == CHAR_MINUS);
                stage_step = ST_SIGN;
                if (frac_reg)
                    fcount_step = fcount_reg + 1'b1;
            end
            else
            begin
                if (stage_reg != ST_DIGITS)
                    inv_step = 1'b1;
                stage_step = ST_STOPPED;
            end
        end

        priority if (accept && (empty_text || last_char))
        begin
            stage_next  = ST_WS;
            frac_next   = 1'b0;
            fcount_next = '0;
            neg_next    = 1'b0;
            inv_next    = 1'b0;
        end
        else if (accept)
        begin
            stage_next  = stage_step;
            frac_next   = frac_step;
            fcount_next = fcount_step;
            neg_next    = neg_step;
            inv_next    = inv_step;
        end
        else
        begin
            stage_next  = stage_reg;
            frac_next   = frac_reg;
            fcount_next = fcount_reg;
            neg_next    = neg_reg;
            inv_next    = inv_reg;
        end
    end

    // Request to the back end
    always_comb
    begin
        pad_calc = (fraction_places > fcount_step) ? (fraction_places - fcount_step) : '0;
        q_entry  = '0;
        if (empty_text)
        begin
            q_entry.discard = 1'b1;
            q_entry.finish  = 1'b1;
            q_entry.pad     = fraction_places;
            q_entry.invalid = (fraction_places == '0);
        end
        else
        begin
            q_entry.has_digit = !skip && is_digit;
            q_entry.digit     = 4'(text_char - CHAR_ZERO);
            q_entry.finish    = last_char;
            q_entry.pad       = pad_calc;
            q_entry.invalid   = inv_step
                                || (((stage_step == ST_WS) || (stage_step == ST_SIGN))
                                    && (pad_calc == '0));
            q_entry.neg       = neg_step;
        end
        q_push = accept && (empty_text || last_char || q_entry.has_digit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= ST_WS;
            frac_reg   <= 1'b0;
            fcount_reg <= '0;
            neg_reg    <= 1'b0;
            inv_reg    <= 1'b0;
        end
        else
        begin
            stage_reg  <= stage_next;
            frac_reg   <= frac_next;
            fcount_reg <= fcount_next;
            neg_reg    <= neg_next;
            inv_reg    <= inv_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dtsi_queue.sv =====
// Short request queue between the front end and the arithmetic back end.
// Depends on dtsi_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module dtsi_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dtsi_pkg::qent_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output dtsi_pkg::qent_t      head,
    output logic                 not_empty
);
    import dtsi_pkg::*;

    qent_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dtsi_back.sv =====
// Back end: multiply-by-ten accumulator with range check, zero padding
// sequencer and registered result stage. Depends on dtsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtsi_back
#(
    parameter int RESULT_WIDTH = 64
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         narrow_result,
    input  wire logic                         q_valid,
    input  wire dtsi_pkg::qent_t              q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [dtsi_pkg::VALUE_W-1:0] scaled_value,
    output dtsi_pkg::status_t                 parse_status
);
    import dtsi_pkg::*;

    localparam int EXT_W = RESULT_WIDTH + 4;

    bk_state_t                 state_reg, state_next;
    logic [RESULT_WIDTH-1:0]   acc_reg, acc_next;
    logic                      ovf_reg, ovf_next;
    logic [PLACES_W-1:0]       pad_reg, pad_next;
    logic                      neg_reg, neg_next;
    logic                      inv_reg, inv_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t                   out_status_reg, out_status_next;

    // Shared multiply-add unit
    logic [RESULT_WIDTH-1:0]   mac_acc;
    logic                      mac_ovf;
    logic [3:0]                mac_digit;
    logic                      mac_neg;
    logic [EXT_W-1:0]          mac_top, mac_lim, mac_prod;
    logic [RESULT_WIDTH-1:0]   mac_acc_out;
    logic                      mac_ovf_out;

    logic                      out_free;
    logic signed [RESULT_WIDTH-1:0] signed_acc;

    assign out_free     = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign scaled_value = out_value_reg;
    assign parse_status = out_status_reg;

    always_comb
    begin
        if (state_reg == BK_PAD)
        begin
            mac_acc   = acc_reg;
            mac_ovf   = ovf_reg;
            mac_digit = '0;
            mac_neg   = neg_reg;
        end
        else
        begin
            mac_acc   = q_head.discard ? '0 : acc_reg;
            mac_ovf   = q_head.discard ? 1'b0 : ovf_reg;
            mac_digit = q_head.digit;
            mac_neg   = q_head.neg;
        end
        mac_top  = narrow_result ? (EXT_W'(1) << 31) : (EXT_W'(1) << (RESULT_WIDTH - 1));
        mac_lim  = mac_neg ? mac_top : (mac_top - 1'b1);
        mac_prod = (EXT_W'(mac_acc) << 3) + (EXT_W'(mac_acc) << 1) + EXT_W'(mac_digit);
        mac_ovf_out = mac_ovf || (mac_prod > mac_lim);
        mac_acc_out = mac_ovf_out ? mac_acc : mac_prod[RESULT_WIDTH-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
                if (q_valid && q_head.finish)
                    state_next = (q_head.pad != '0) ? BK_PAD : BK_DONE;
            BK_PAD:
                if (pad_reg == PLACES_W'(1))
                    state_next = BK_DONE;
            BK_DONE:
                if (out_free)
                    state_next = BK_RUN;
            default:
                state_next = BK_RUN;
        endcase
    end

    // Datapath control
    always_comb
    begin
        q_pop           = 1'b0;
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        pad_next        = pad_reg;
        neg_next        = neg_reg;
        inv_next        = inv_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        signed_acc      = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        unique case (state_reg)
            BK_RUN:
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.has_digit)
                    begin
                        acc_next = mac_acc_out;
                        ovf_next = mac_ovf_out;
                    end
                    else
                    begin
                        acc_next = mac_acc;
                        ovf_next = mac_ovf;
                    end
                    if (q_head.finish)
                    begin
                        pad_next = q_head.pad;
                        neg_next = q_head.neg;
                        inv_next = q_head.invalid;
                    end
                end
            BK_PAD:
            begin
                acc_next = mac_acc_out;
                ovf_next = mac_ovf_out;
                pad_next = pad_reg - 1'b1;
            end
            BK_DONE:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    priority if (inv_reg)
                    begin
                        out_value_next  = '0;
                        out_status_next = PS_INVALID;
                    end
                    else if (ovf_reg)
                    begin
                        out_value_next  = '0;
                        out_status_next = PS_RANGE;
                    end
                    else
                    begin
                        out_value_next  = VALUE_W'(signed_acc);
                        out_status_next = PS_OK;
                    end
                    // Start the next text from a clean accumulator
                    acc_next = '0;
                    ovf_next = 1'b0;
                end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            pad_reg       <= '0;
            neg_reg       <= 1'b0;
            inv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            pad_reg       <= pad_next;
            neg_reg       <= neg_next;
            inv_reg       <= inv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_text_to_scaled_integer_core.sv =====
// Top level of the decimal text to scaled integer core: configuration
// registers, front end, request queue and arithmetic back end.
// Depends on dtsi_pkg, dtsi_front, dtsi_queue, dtsi_back.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  input    | in_valid / in_stall | text_char, last_char, empty_text
//  output   | out_valid/out_stall | scaled_value, parse_status
//  config   | cfg_wr_en           | cfg_index, cfg_data
//
// One character is taken per cycle while the four-entry queue has room.
// After its last character the back end appends pad zero digits to each text,
// pad being the missing fraction places (0..31): one multiply-by-ten per cycle.
// Reset clears parse state, queue and result valid; fraction_places resets to 3.
// A stalled result holds in the output register while characters keep flowing
// until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_scaled_integer_core
#(
    parameter int RESULT_WIDTH = 64
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [dtsi_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        text_char,
    input  wire logic                              last_char,
    input  wire logic                              empty_text,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [dtsi_pkg::VALUE_W-1:0]    scaled_value,
    output logic [1:0]                             parse_status
);
    import dtsi_pkg::*;

    logic [PLACES_W-1:0] fraction_places_reg, fraction_places_next;
    logic                narrow_result_reg, narrow_result_next;

    logic    q_push, q_full, q_pop, q_not_empty;
    qent_t   q_entry, q_head;
    status_t status;

    assign parse_status = status;

    always_comb
    begin
        fraction_places_next = fraction_places_reg;
        narrow_result_next   = narrow_result_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRACTION_PLACES: fraction_places_next = cfg_data[PLACES_W-1:0];
                CFG_NARROW_RESULT:   narrow_result_next   = cfg_data[0];
                default:             fraction_places_next = fraction_places_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_places_reg <= PLACES_RESET;
            narrow_result_reg   <= 1'b0;
        end
        else
        begin
            fraction_places_reg <= fraction_places_next;
            narrow_result_reg   <= narrow_result_next;
        end
    end

    dtsi_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .text_char       (text_char),
        .last_char       (last_char),
        .empty_text      (empty_text),
        .fraction_places (fraction_places_reg),
        .q_push          (q_push),
        .q_entry         (q_entry),
        .q_full          (q_full)
    );

    dtsi_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty)
    );

    dtsi_back #(
        .RESULT_WIDTH (RESULT_WIDTH)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .narrow_result (narrow_result_reg),
        .q_valid       (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scaled_value  (scaled_value),
        .parse_status  (status)
    );

    // Front never writes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

    // Back never takes from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("request popped from empty queue");

    // Error results carry a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != PS_OK)) |-> (scaled_value == '0))
        else $error("error result with nonzero value");

endmodule

`default_nettype wire

// ===== tb/decimal_text_to_scaled_integer_core_tb.sv =====
// Self-checking testbench for decimal_text_to_scaled_integer_core.
// Drives decimal text character by character and checks every scaled result
// against a built-in predictor. Depends on dtsi_pkg and the core.
`timescale 1ns / 1ps

module decimal_text_to_scaled_integer_core_tb;

    import dtsi_pkg::*;

    localparam int RESULT_W     = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 50;
    localparam int N_SETTINGS   = 11;
    localparam int PHASE_ITEMS  = 60;
    localparam int MAX_REPORTS  = 30;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } char_req_t;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
    } parse_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_index = CFG_FRACTION_PLACES;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             text_char = '0;
    logic                   last_char = 1'b0;
    logic                   empty_text = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [VALUE_W-1:0] scaled_value;
    logic [1:0]             parse_status;

    decimal_text_to_scaled_integer_core #(
        .RESULT_WIDTH (RESULT_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_char    (text_char),
        .last_char    (last_char),
        .empty_text   (empty_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scaled_value (scaled_value),
        .parse_status (parse_status)
    );

    always #5 clk = ~clk;

    // Predictor state and register copies
    logic [PLACES_W-1:0] places_reg = PLACES_RESET;
    logic                narrow_reg = 1'b0;
    logic [63:0]         acc_mag;
    logic [PLACES_W-1:0] frac_taken;
    stage_t              txt_stage;
    logic                in_frac;
    logic                is_neg;
    logic                ovf_seen;
    logic                bad_text;

    char_req_t     pending_chars[$];
    parse_result_t predicted_q[$];
    char_req_t     next_req;
    logic          in_taken = 1'b0;
    int            in_idle_pct = 0;
    int            out_idle_pct = 0;
    int            cycle_count = 0;
    int            mismatches = 0;
    int            chars_taken = 0;
    int            texts_checked = 0;

    function automatic void clear_text();
        acc_mag    = '0;
        frac_taken = '0;
        txt_stage  = ST_WS;
        in_frac    = 1'b0;
        is_neg     = 1'b0;
        ovf_seen   = 1'b0;
        bad_text   = 1'b0;
    endfunction

    function automatic logic [63:0] magnitude_cap();
        logic [63:0] top;
        top = narrow_reg ? (64'd1 << 31) : (64'd1 << (RESULT_W - 1));
        return is_neg ? top : top - 64'd1;
    endfunction

    function automatic void add_digit(logic [3:0] d);
        logic [63:0] cap;
        cap = magnitude_cap();
        if (ovf_seen)
            return;
        if (acc_mag > (cap - 64'(d)) / 64'd10)
            ovf_seen = 1'b1;
        else
            acc_mag = acc_mag * 64'd10 + 64'(d);
    endfunction

    function automatic void feed_char(logic [7:0] c);
        logic is_space;
        is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        if (txt_stage == ST_STOPPED)
            return;
        // fraction already full: everything else is dropped
        if (in_frac && frac_taken >= places_reg)
            return;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            add_digit(4'(c - CHAR_ZERO));
            txt_stage = ST_DIGITS;
            if (in_frac)
                frac_taken++;
        end else if (c == CHAR_DOT && !in_frac) begin
            in_frac = 1'b1;
        end else if (txt_stage == ST_WS && is_space) begin
            if (in_frac)
                frac_taken++;
        end else if (txt_stage == ST_WS && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
            is_neg    = (c == CHAR_MINUS);
            txt_stage = ST_SIGN;
            if (in_frac)
                frac_taken++;
        end else begin
            if (txt_stage != ST_DIGITS)
                bad_text = 1'b1;
            txt_stage = ST_STOPPED;
        end
    endfunction

    function automatic void close_text();
        logic [PLACES_W-1:0] pad;
        parse_result_t       r;
        pad = (places_reg > frac_taken) ? places_reg - frac_taken : '0;
        // padding zeros count as digits
        if (!bad_text && (txt_stage == ST_WS || txt_stage == ST_SIGN) && pad == 0)
            bad_text = 1'b1;
        for (int i = 0; i < pad; i++)
            add_digit(4'd0);
        if (bad_text) begin
            r.value  = '0;
            r.status = PS_INVALID;
        end else if (ovf_seen) begin
            r.value  = '0;
            r.status = PS_RANGE;
        end else begin
            r.value  = is_neg ? -acc_mag : acc_mag;
            r.status = PS_OK;
        end
        predicted_q.insert(predicted_q.size(), r);
        clear_text();
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatches++;
    endtask

    // Driver: inputs change on the falling edge
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    next_req = pending_chars.pop_front();
                    in_valid   <= 1'b1;
                    text_char  <= next_req.ch;
                    last_char  <= next_req.last;
                    empty_text <= next_req.empty;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk) begin
        in_taken <= in_valid && !in_stall;
        if (rst_n) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Verification failed");
                $finish;
            end
            if (in_valid && !in_stall) begin
                chars_taken++;
                if (empty_text) begin
                    // drop any partial text first
                    clear_text();
                    close_text();
                end else begin
                    feed_char(text_char);
                    if (last_char)
                        close_text();
                end
            end
            if (out_valid && !out_stall) begin
                if (predicted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d status %0d",
                                              scaled_value, parse_status));
                end else begin
                    parse_result_t want;
                    want = predicted_q.pop_front();
                    if (scaled_value !== want.value)
                        report_mismatch($sformatf("text %0d: value %0d, expected %0d",
                                                  texts_checked, scaled_value,
                                                  $signed(want.value)));
                    if (parse_status !== want.status)
                        report_mismatch($sformatf("text %0d: status %0d, expected %0d",
                                                  texts_checked, parse_status, want.status));
                    texts_checked++;
                end
            end
        end
    end

    task automatic put_byte(ref byte unsigned txt[$], input logic [7:0] b);
        txt.insert(txt.size(), b);
    endtask

    task automatic add_char(logic [7:0] ch, logic last, logic empty);
        char_req_t req;
        req.ch    = ch;
        req.last  = last;
        req.empty = empty;
        pending_chars.insert(pending_chars.size(), req);
    endtask

    task automatic add_text(byte unsigned txt[$]);
        foreach (txt[i])
            add_char(txt[i], i == txt.size() - 1, 1'b0);
    endtask

    task automatic add_string(string s);
        byte unsigned txt[$];
        for (int i = 0; i < s.len(); i++)
            put_byte(txt, s[i]);
        add_text(txt);
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_FRACTION_PLACES)
            places_reg = data;
        else
            narrow_reg = data[0];
    endtask

    // Sample on the rising edge, where the driven inputs are settled
    task automatic drain();
        do
            @(posedge clk);
        while (pending_chars.size() != 0 || in_valid || predicted_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic build_number(ref byte unsigned txt[$]);
        int r;
        int n_int;
        int n_frac;
        r = $urandom_range(9);
        n_int = (r == 0) ? 0 : (r < 7) ? $urandom_range(1, 5) : $urandom_range(6, 20);
        n_frac = $urandom_range(0, (places_reg > 20) ? 22 : places_reg + 2);
        repeat ($urandom_range(2))
            put_byte(txt, ($urandom_range(3) == 0) ? CHAR_SPACE
                                                   : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
        if ($urandom_range(1))
            put_byte(txt, $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
        repeat (n_int)
            put_byte(txt, 8'(CHAR_ZERO + $urandom_range(9)));
        if ($urandom_range(9) < 7) begin
            put_byte(txt, CHAR_DOT);
            repeat (n_frac)
                put_byte(txt, 8'(CHAR_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(6) == 0)
            repeat ($urandom_range(1, 3))
                put_byte(txt, 8'($urandom_range(255)));
        if (txt.size() == 0)
            put_byte(txt, 8'(CHAR_ZERO + $urandom_range(9)));
    endtask

    // Digits right at the signed limit of the current width, scaled by places
    task automatic build_boundary(ref byte unsigned txt[$]);
        logic [63:0] v;
        string       s;
        int          len;
        v = narrow_reg ? 64'd2147483647 : 64'h7FFF_FFFF_FFFF_FFFF;
        v = v + 64'($urandom_range(4)) - 64'd2;
        s = $sformatf("%0d", v);
        len = s.len();
        if ($urandom_range(1))
            put_byte(txt, CHAR_MINUS);
        if (places_reg > len)
            put_byte(txt, CHAR_DOT);
        for (int i = 0; i < len; i++) begin
            if (places_reg != 0 && places_reg <= len && i == len - places_reg)
                put_byte(txt, CHAR_DOT);
            put_byte(txt, s[i]);
        end
    endtask

    task automatic random_texts(int n_items);
        byte unsigned txt[$];
        int           kind;
        int           goal;
        goal = pending_chars.size() + n_items;
        while (pending_chars.size() < goal) begin
            txt.delete();
            kind = $urandom_range(99);
            if (kind < 60) begin
                build_number(txt);
            end else if (kind < 75) begin
                build_boundary(txt);
            end else if (kind < 85) begin
                build_number(txt);
                case ($urandom_range(4))
                    0: txt.insert($urandom_range(txt.size()), CHAR_DOT);
                    1: txt.insert($urandom_range(txt.size()), CHAR_PLUS);
                    2: txt.insert($urandom_range(txt.size()), CHAR_MINUS);
                    3: txt.insert($urandom_range(txt.size()), CHAR_SPACE);
                    default: txt.insert($urandom_range(txt.size()), 8'($urandom_range(255)));
                endcase
            end else if (kind < 93) begin
                repeat ($urandom_range(1, 6))
                    put_byte(txt, 8'($urandom_range(255)));
            end
            if (txt.size() != 0) begin
                add_text(txt);
            end else begin
                // empty text, sometimes cutting a partial one short
                repeat ($urandom_range(2))
                    add_char(8'(CHAR_ZERO + $urandom_range(9)), 1'b0, 1'b0);
                add_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            end
        end
    endtask

    logic [PLACES_W-1:0] places_list[N_SETTINGS] =
        '{5'd0, 5'd18, 5'd3, 5'd9, 5'd0, 5'd18, 5'd31, 5'd2, 5'd6, 5'd12, 5'd25};
    logic                narrow_list[N_SETTINGS] =
        '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    initial begin
        clear_text();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        in_idle_pct  = 33;
        out_idle_pct = 84;

        // Directed texts on reset register values (3 places, 64-bit)
        add_string(" -1.5");
        add_string("+.1234");
        add_string("x");
        add_string("4a9");
        add_string(".");
        add_char(8'h00, 1'b1, 1'b1);
        add_string("-+1");
        add_char(8'hFF, 1'b1, 1'b0);
        add_char(CHAR_ZERO + 8'd5, 1'b0, 1'b0);
        add_char(8'hFF, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < N_SETTINGS; p++) begin
            if (p == 4) begin
                in_idle_pct  = 84;
                out_idle_pct = 33;
            end else if (p == 8) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            write_reg(CFG_FRACTION_PLACES, places_list[p]);
            write_reg(CFG_NARROW_RESULT, CFG_DATA_W'(narrow_list[p]));
            random_texts(PHASE_ITEMS);
            drain();
        end

        if (predicted_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_q.size()));
        $display("Run covered %0d characters and %0d parsed texts over %0d register settings",
                 chars_taken, texts_checked, N_SETTINGS + 1);
        $display("Mismatches seen: %0d", mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dtsi_pkg.sv
hw/rtl/dtsi_front.sv
hw/rtl/dtsi_queue.sv
hw/rtl/dtsi_back.sv
hw/rtl/decimal_text_to_scaled_integer_core.sv
tb/decimal_text_to_scaled_integer_core_tb.sv
